// ----- hdl/sst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the sorted set table
// Table size, field widths, request and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int TABLE_CAPACITY = 64;
   localparam int KEY_W          = 32;
   localparam int IDX_W          = $clog2(TABLE_CAPACITY);
   localparam int CNT_W          = $clog2(TABLE_CAPACITY + 1);
   localparam int REQ_W          = 2;
   localparam int ST_W           = 2;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

   localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
   localparam logic [ST_W-1:0] ST_PRESENT = 2'd1;
   localparam logic [ST_W-1:0] ST_ABSENT  = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

   // control broadcast to every cell
   typedef struct packed {
      logic                    capture;    // compare phase: latch flags
      logic                    shift_up;   // insert: open a slot at the boundary
      logic                    shift_down; // delete: close the slot at the boundary
      logic signed [KEY_W-1:0] cmp_key;    // key compared in the capture cycle
      logic signed [KEY_W-1:0] ins_key;    // key written on insert
   } cell_ctrl_type;

endpackage

// ----- hdl/sst_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cell: one entry of the sorted set table
// Holds one value, compares it against the key and shifts with its neighbors.
// ----------------------------------------------------------------------------
module sst_cell (
   input  logic                              clock,
   input  sst_pkg::cell_ctrl_type            cell_ctrl,
   input  logic [sst_pkg::IDX_W-1:0]         cell_idx,
   input  logic [sst_pkg::CNT_W-1:0]         held_count,
   input  logic                              left_le,
   input  logic signed [sst_pkg::KEY_W-1:0]  left_value,
   input  logic signed [sst_pkg::KEY_W-1:0]  right_value,
   output logic                              cell_le,
   output logic                              cell_eq,
   output logic                              cell_bound,
   output logic signed [sst_pkg::KEY_W-1:0]  cell_value
);
   import sst_pkg::*;

   logic signed [KEY_W-1:0] value_ff, value_in;
   logic                    le_ff, le_in;
   logic                    eq_ff, eq_in;
   logic                    occupied;

   // le: key belongs at or before this entry (empty entries count as yes)
   always_comb begin
      occupied = CNT_W'(cell_idx) < held_count;
      le_in    = le_ff;
      eq_in    = eq_ff;
      if (cell_ctrl.capture) begin
         le_in = !occupied || (value_ff >= cell_ctrl.cmp_key);
         eq_in = occupied && (value_ff == cell_ctrl.cmp_key);
      end
   end

   assign cell_bound = le_ff && !left_le;

   always_comb begin
      value_in = value_ff;
      if (cell_ctrl.shift_up) begin
         if (cell_bound) begin
            value_in = cell_ctrl.ins_key;
         end else if (left_le) begin
            value_in = left_value;
         end
      end else if (cell_ctrl.shift_down && le_ff) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      le_ff    <= le_in;
      eq_ff    <= eq_in;
   end

   assign cell_le    = le_ff;
   assign cell_eq    = eq_ff;
   assign cell_value = value_ff;

endmodule

// ----- hdl/sorted_set_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_table: set of distinct signed values kept in ascending order
// Row of compare-and-shift cells with insert, delete and lookup requests.
// ----------------------------------------------------------------------------
// Each item is handled in turn: on accept every cell compares its value with
// the key at once, latching its flags; while busy, the cells shift in place
// (insert or delete), the count updates and the result is registered.
// rsp_strobe is registered together with the result and is high for exactly
// one cycle; the receiver cannot hold it off, so results must be taken when
// strobed. busy is high only in the shift cycle, so start may be held high
// to issue items back to back, each after the prior shift. Position is the
// sorted index of the key when held or newly inserted, otherwise the count.
// An insert into a full table is dropped with status ST_FULL. Unused request
// code 3 acts as a lookup. Entries at or above the count never affect a
// comparison.
module sorted_set_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sst_pkg::REQ_W-1:0]         req_type,
   input  logic signed [sst_pkg::KEY_W-1:0]  req_key_value,
   output logic                              rsp_strobe,
   output logic [sst_pkg::ST_W-1:0]          rsp_status,
   output logic [sst_pkg::CNT_W-1:0]         rsp_position,
   output logic [sst_pkg::CNT_W-1:0]         rsp_count
);
   import sst_pkg::*;

   // control
   logic                    pend_ff, pend_in;
   logic                    accept;
   logic [REQ_W-1:0]        type_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [CNT_W-1:0]        count_ff, count_in;

   // result registers
   logic                    strobe_ff;
   logic [ST_W-1:0]         status_ff, status_in;
   logic [CNT_W-1:0]        position_ff, position_in;

   // cell row
   cell_ctrl_type           cell_ctrl;
   logic [TABLE_CAPACITY-1:0] le_vec, eq_vec, bound_vec;
   logic signed [KEY_W-1:0] value_vec [TABLE_CAPACITY];

   // decode of the shift cycle
   logic                    held;
   logic                    full;
   logic [IDX_W-1:0]        at_idx;
   logic                    do_insert, do_delete;

   assign accept  = start && !pend_ff;
   assign pend_in = accept;

   always_comb begin
      held = |eq_vec;
      full = count_ff == CNT_W'(TABLE_CAPACITY);
      // boundary is one-hot, so an OR of indexes encodes it
      at_idx = '0;
      for (int i = 0; i < TABLE_CAPACITY; i++) begin
         if (bound_vec[i]) at_idx = at_idx | IDX_W'(i);
      end
   end

   assign do_insert = pend_ff && (type_ff == REQ_INSERT) && !held && !full;
   assign do_delete = pend_ff && (type_ff == REQ_DELETE) && held;

   always_comb begin
      cell_ctrl.capture    = accept;
      cell_ctrl.shift_up   = do_insert;
      cell_ctrl.shift_down = do_delete;
      cell_ctrl.cmp_key    = req_key_value;
      cell_ctrl.ins_key    = key_ff;
   end

   always_comb begin
      count_in    = count_ff;
      status_in   = ST_ABSENT;
      position_in = count_ff;
      if (pend_ff) begin
         case (type_ff)
            REQ_INSERT: begin
               if (held) begin
                  status_in   = ST_PRESENT;
                  position_in = CNT_W'(at_idx);
               end else if (full) begin
                  status_in   = ST_FULL;
               end else begin
                  status_in   = ST_DONE;
                  position_in = CNT_W'(at_idx);
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            REQ_DELETE: begin
               if (held) begin
                  status_in   = ST_DONE;
                  position_in = CNT_W'(at_idx);
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            default: begin
               // lookup and the unused code
               if (held) begin
                  status_in   = ST_DONE;
                  position_in = CNT_W'(at_idx);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         pend_ff   <= pend_in;
         strobe_ff <= pend_ff;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         key_ff  <= req_key_value;
      end
      if (pend_ff) begin
         status_ff   <= status_in;
         position_ff <= position_in;
      end
   end

   // row of cells, each tied to its two neighbors
   for (genvar g = 0; g < TABLE_CAPACITY; g++) begin : g_cell
      logic                    left_le;
      logic signed [KEY_W-1:0] left_value;
      logic signed [KEY_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_le    = 1'b0;
         assign left_value = key_ff;
      end else begin : g_mid
         assign left_le    = le_vec[g-1];
         assign left_value = value_vec[g-1];
      end

      if (g == TABLE_CAPACITY - 1) begin : g_last
         assign right_value = value_vec[g];
      end else begin : g_inner
         assign right_value = value_vec[g+1];
      end

      sst_cell u_cell (
         .clock       (clock),
         .cell_ctrl   (cell_ctrl),
         .cell_idx    (IDX_W'(g)),
         .held_count  (count_ff),
         .left_le     (left_le),
         .left_value  (left_value),
         .right_value (right_value),
         .cell_le     (le_vec[g]),
         .cell_eq     (eq_vec[g]),
         .cell_bound  (bound_vec[g]),
         .cell_value  (value_vec[g])
      );
   end

   assign busy         = pend_ff;
   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_position = position_ff;
   assign rsp_count    = count_ff;

`ifndef ASSERT_OFF
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("result strobe missing two cycles after accept");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_CAPACITY))
      else $error("held count above capacity");

   a_bound_onehot: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $onehot0(bound_vec) && $onehot0(eq_vec))
      else $error("insert boundary or match not unique");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> rsp_count == CNT_W'(TABLE_CAPACITY))
      else $error("full status with room left");

   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      !(busy && rsp_strobe))
      else $error("strobe during shift cycle");
`endif

endmodule
